[rtl/e164_pkg.sv]
// Shared types and constants for the E.164 to ENUM domain builder.
// Used by the controller, the datapath, the top level and the testbench.
// No dependencies.
`timescale 1ns / 1ps

package e164_pkg;

	// Digit store depth and the count, capacity and need widths.
	localparam int MAX_DIGITS = 15;
	localparam int CNT_W      = 4;
	localparam int CAP_W      = 11;
	localparam int NEED_W     = 12;

	localparam logic [CAP_W-1:0] CAP_RESET   = 11'd256;
	localparam logic [CAP_W-1:0] LEN_MAX     = 11'd2047;

	// Characters that the number and label rules look at.
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;

	// Run status, sent on the last beat of a run.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_TOO_MANY = 2'd2,
		ST_NO_SPACE = 2'd3
	} status_t;

	// What the output register is loaded with.
	typedef enum logic [2:0] {
		SEL_ECHO,
		SEL_ECHO_LAST,
		SEL_DIGIT,
		SEL_POINT,
		SEL_DOT_LAST
	} out_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     accept;
		logic     load_out;
		out_sel_t sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic obuf_free;
		logic is_apex;
		logic is_final;
		logic ends_dot;
		logic emit_go;
		logic idx_one;
		logic idx_nonzero;
	} sts_t;

endpackage

[rtl/e164_if.sv]
// Valid/ready channel interfaces for input characters and output domain characters.
// Depends on e164_pkg for nothing but is compiled after it.
`timescale 1ns / 1ps

interface e164_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_apex;
	logic       is_final;

	modport source (output valid, in_byte, is_apex, is_final, input ready);
	modport sink (input valid, in_byte, is_apex, is_final, output ready);
endinterface

interface e164_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, out_byte, status, last, input ready);
	modport sink (input valid, out_byte, status, last, output ready);
endinterface

[rtl/e164_dp.sv]
// Datapath: digit store, number and label checks, run status and output register.
// Depends on e164_pkg; driven by commands from e164_ctrl.
`timescale 1ns / 1ps

module e164_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [e164_pkg::CAP_W-1:0] cfg_wdata,
	input  logic [7:0]               in_byte,
	input  logic                     is_apex,
	input  logic                     is_final,
	input  e164_pkg::cmd_t           cmd,
	output e164_pkg::sts_t           sts,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               out_byte,
	output logic [1:0]               out_status,
	output logic                     out_last
);

	logic [3:0]                   digit_store [e164_pkg::MAX_DIGITS];
	logic [e164_pkg::CNT_W-1:0]   digit_count_q;
	logic                         plus_seen_q;
	logic                         nonspace_seen_q;
	e164_pkg::status_t            number_error_q;
	logic                         apex_bad_q;
	logic                         label_nonempty_q;
	logic [e164_pkg::CAP_W-1:0]   apex_length_q;
	logic [e164_pkg::CAP_W-1:0]   capacity_q;
	logic [e164_pkg::CNT_W-1:0]   emit_idx_q;
	e164_pkg::status_t            final_status_q;

	logic                         ob_valid_q;
	logic [7:0]                   ob_byte_q;
	e164_pkg::status_t            ob_status_q;
	logic                         ob_last_q;

	// Character classes.
	logic is_digit, is_alnum, is_skip, is_dot;
	logic [3:0] digit_val;

	assign is_digit  = (in_byte >= e164_pkg::CH_ZERO) && (in_byte <= e164_pkg::CH_NINE);
	assign is_alnum  = is_digit
		|| ((in_byte >= e164_pkg::CH_LC_A) && (in_byte <= e164_pkg::CH_LC_Z))
		|| ((in_byte >= e164_pkg::CH_UC_A) && (in_byte <= e164_pkg::CH_UC_Z));
	assign is_dot    = (in_byte == e164_pkg::CH_DOT);
	assign is_skip   = (in_byte == e164_pkg::CH_SPACE) || (in_byte == e164_pkg::CH_TAB)
		|| (in_byte == e164_pkg::CH_DASH) || (in_byte == e164_pkg::CH_LPAREN)
		|| (in_byte == e164_pkg::CH_RPAREN) || is_dot;
	assign digit_val = 4'(in_byte - e164_pkg::CH_ZERO);

	// Number part: next values of the number state for this character.
	logic                       num_wr;
	logic [e164_pkg::CNT_W-1:0] cnt_n;
	e164_pkg::status_t          err_n;
	logic                       plus_n, nonspace_n;
	logic [3:0]                 first_n;

	always_comb begin
		num_wr     = 1'b0;
		cnt_n      = digit_count_q;
		err_n      = number_error_q;
		plus_n     = plus_seen_q;
		nonspace_n = nonspace_seen_q;
		if (number_error_q == e164_pkg::ST_OK) begin
			if (is_digit) begin
				if (digit_count_q >= e164_pkg::CNT_W'(e164_pkg::MAX_DIGITS)) begin
					err_n = e164_pkg::ST_TOO_MANY;
				end else begin
					num_wr     = 1'b1;
					cnt_n      = digit_count_q + 1'b1;
					nonspace_n = 1'b1;
				end
			end else if (in_byte == e164_pkg::CH_PLUS) begin
				if (plus_seen_q || nonspace_seen_q) begin
					err_n = e164_pkg::ST_INVALID;
				end else begin
					plus_n     = 1'b1;
					nonspace_n = 1'b1;
				end
			end else if (!is_skip) begin
				err_n = e164_pkg::ST_INVALID;
			end
		end
		first_n = (num_wr && digit_count_q == '0) ? digit_val : digit_store[0];
	end

	// Apex part: label rules and saturating length.
	logic                       bad_n, label_n;
	logic [e164_pkg::CAP_W-1:0] len_n;

	always_comb begin
		bad_n   = apex_bad_q;
		label_n = label_nonempty_q;
		if (is_alnum || in_byte == e164_pkg::CH_DASH) begin
			label_n = 1'b1;
		end else if (is_dot) begin
			if (!label_nonempty_q && !is_final) begin
				bad_n = 1'b1;
			end
			label_n = 1'b0;
		end else begin
			bad_n = 1'b1;
		end
		len_n = (apex_length_q < e164_pkg::LEN_MAX) ? apex_length_q + 1'b1 : apex_length_q;
	end

	// Run status for a final apex character, in priority order.
	logic [e164_pkg::NEED_W-1:0] need;
	logic                        apex_ok;
	e164_pkg::status_t           run_status;

	assign need = e164_pkg::NEED_W'({digit_count_q, 1'b0})
		+ e164_pkg::NEED_W'(len_n) + (is_dot ? 12'd1 : 12'd2);
	assign apex_ok = !bad_n && (label_n || is_dot);

	always_comb begin
		priority if (capacity_q == '0 || !apex_ok) begin
			run_status = e164_pkg::ST_INVALID;
		end else if (number_error_q != e164_pkg::ST_OK) begin
			run_status = number_error_q;
		end else if (digit_count_q == '0 || digit_store[0] == 4'd0) begin
			run_status = e164_pkg::ST_INVALID;
		end else if (need > e164_pkg::NEED_W'(capacity_q)) begin
			run_status = e164_pkg::ST_NO_SPACE;
		end else begin
			run_status = e164_pkg::ST_OK;
		end
	end

	// Status toward the controller.
	assign sts.obuf_free   = !ob_valid_q || out_ready;
	assign sts.is_apex     = is_apex;
	assign sts.is_final    = is_final;
	assign sts.ends_dot    = is_dot;
	assign sts.emit_go     = !is_apex && is_final && err_n == e164_pkg::ST_OK
		&& cnt_n != '0 && first_n != 4'd0;
	assign sts.idx_one     = (emit_idx_q == e164_pkg::CNT_W'(1));
	assign sts.idx_nonzero = (emit_idx_q != '0);

	// Digit store: plain registers, no reset; only entries below the count are read.
	always_ff @(posedge clk) begin
		if (cmd.accept && !is_apex && num_wr) begin
			digit_store[digit_count_q] <= digit_val;
		end
	end

	// Run state, configuration and emit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q    <= '0;
			plus_seen_q      <= 1'b0;
			nonspace_seen_q  <= 1'b0;
			number_error_q   <= e164_pkg::ST_OK;
			apex_bad_q       <= 1'b0;
			label_nonempty_q <= 1'b0;
			apex_length_q    <= '0;
			capacity_q       <= e164_pkg::CAP_RESET;
			emit_idx_q       <= '0;
			final_status_q   <= e164_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (cmd.accept && !is_apex) begin
				digit_count_q   <= cnt_n;
				number_error_q  <= err_n;
				plus_seen_q     <= plus_n;
				nonspace_seen_q <= nonspace_n;
				if (sts.emit_go) begin
					emit_idx_q <= cnt_n;
				end
			end else if (cmd.accept && is_apex && !is_final) begin
				apex_bad_q       <= bad_n;
				label_nonempty_q <= label_n;
				apex_length_q    <= len_n;
			end else if (cmd.accept && is_apex) begin
				// End of run: the number and apex state return to reset; the capacity is kept.
				final_status_q   <= run_status;
				digit_count_q    <= '0;
				plus_seen_q      <= 1'b0;
				nonspace_seen_q  <= 1'b0;
				number_error_q   <= e164_pkg::ST_OK;
				apex_bad_q       <= 1'b0;
				label_nonempty_q <= 1'b0;
				apex_length_q    <= '0;
			end
			if (cmd.load_out && cmd.sel == e164_pkg::SEL_POINT) begin
				emit_idx_q <= emit_idx_q - 1'b1;
			end
		end
	end

	// Output register contents for each kind of beat.
	logic [e164_pkg::CNT_W-1:0] rd_idx;
	logic [7:0]                 nxt_byte;
	e164_pkg::status_t          nxt_status;
	logic                       nxt_last;

	assign rd_idx = emit_idx_q - 1'b1;

	always_comb begin
		nxt_byte   = in_byte;
		nxt_status = e164_pkg::ST_OK;
		nxt_last   = 1'b0;
		unique case (cmd.sel)
			e164_pkg::SEL_ECHO: begin
				nxt_byte = in_byte;
			end
			e164_pkg::SEL_ECHO_LAST: begin
				nxt_byte   = in_byte;
				nxt_status = run_status;
				nxt_last   = 1'b1;
			end
			e164_pkg::SEL_DIGIT: begin
				nxt_byte = e164_pkg::CH_ZERO + {4'd0, digit_store[rd_idx]};
			end
			e164_pkg::SEL_POINT: begin
				nxt_byte = e164_pkg::CH_DOT;
			end
			e164_pkg::SEL_DOT_LAST: begin
				nxt_byte   = e164_pkg::CH_DOT;
				nxt_status = final_status_q;
				nxt_last   = 1'b1;
			end
			default: begin
				nxt_byte = in_byte;
			end
		endcase
	end

	// Output register: holds one beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			ob_valid_q <= 1'b1;
		end else if (out_ready) begin
			ob_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ob_byte_q   <= nxt_byte;
			ob_status_q <= nxt_status;
			ob_last_q   <= nxt_last;
		end
	end

	assign out_valid  = ob_valid_q;
	assign out_byte   = ob_byte_q;
	assign out_status = ob_status_q;
	assign out_last   = ob_last_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= e164_pkg::CNT_W'(e164_pkg::MAX_DIGITS))
		else $error("digit count beyond store depth");

	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ob_valid_q && !ob_last_q) |-> (ob_status_q == e164_pkg::ST_OK))
		else $error("nonzero status on a beat that is not last");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && is_apex && is_final) |=> (digit_count_q == '0 && apex_length_q == '0))
		else $error("run state not cleared after final apex character");
`endif

endmodule

[rtl/e164_ctrl.sv]
// Controller: accepts characters and sequences the reversed digit beats and final dot.
// Depends on e164_pkg; drives e164_dp through cmd and reads its sts.
`timescale 1ns / 1ps

module e164_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  e164_pkg::sts_t sts,
	output e164_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_TAKE,
		S_DIGIT,
		S_POINT,
		S_DOT_LAST
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_TAKE) && sts.obuf_free;

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		cmd.sel      = e164_pkg::SEL_ECHO;
		unique case (state_q)
			S_TAKE: begin
				if (in_valid && in_ready) begin
					cmd.accept = 1'b1;
					if (sts.is_apex) begin
						cmd.load_out = 1'b1;
						if (sts.is_final && sts.ends_dot) begin
							cmd.sel = e164_pkg::SEL_ECHO_LAST;
						end else if (sts.is_final) begin
							state_d = S_DOT_LAST;
						end
					end else if (sts.emit_go) begin
						state_d = S_DIGIT;
					end
				end
			end
			S_DIGIT: begin
				if (sts.obuf_free) begin
					cmd.load_out = 1'b1;
					cmd.sel      = e164_pkg::SEL_DIGIT;
					state_d      = S_POINT;
				end
			end
			S_POINT: begin
				if (sts.obuf_free) begin
					cmd.load_out = 1'b1;
					cmd.sel      = e164_pkg::SEL_POINT;
					state_d      = sts.idx_one ? S_TAKE : S_DIGIT;
				end
			end
			S_DOT_LAST: begin
				if (sts.obuf_free) begin
					cmd.load_out = 1'b1;
					cmd.sel      = e164_pkg::SEL_DOT_LAST;
					state_d      = S_TAKE;
				end
			end
			default: begin
				state_d = S_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT || state_q == S_POINT) |-> sts.idx_nonzero)
		else $error("digit emission with empty index");

	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !sts.is_apex && sts.emit_go) |=> (state_q == S_DIGIT))
		else $error("good final number did not start emission");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.obuf_free)
		else $error("output register overwritten while full");
`endif

endmodule

[rtl/e164_to_enum_domain_top.sv]
// Top level of the E.164 number to ENUM query domain builder.
// Depends on e164_pkg, e164_if, e164_ctrl and e164_dp.
//
//   port      dir   beat contents
//   in_ch     sink  in_byte, is_apex, is_final
//   out_ch    src   out_byte, status, last
//   cfg_we    in    write strobe for domain_capacity (cfg_wdata, 11 bits)
//
// A non-final number character produces no beat; a non-final apex character is echoed.
// A final apex character without a trailing dot is sent as two beats (echo, then dot).
// A final number character of a good number yields 2*N beats for N digits (up to 15),
// a digit then a dot each, one beat per cycle through the single output register while the output is taken.
// Input is held off while the output register is full and not being taken, and while digit and dot beats go out.
// Reset is asynchronous; the capacity returns to 256 and the run state clears.
`timescale 1ns / 1ps

module e164_to_enum_domain_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [e164_pkg::CAP_W-1:0] cfg_wdata,
	e164_in_if.sink                    in_ch,
	e164_out_if.source                 out_ch
);

	e164_pkg::cmd_t cmd;
	e164_pkg::sts_t sts;

	// Sequencer.
	e164_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Checks, digit store and output register.
	e164_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_byte    (in_ch.in_byte),
		.is_apex    (in_ch.is_apex),
		.is_final   (in_ch.is_final),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_byte   (out_ch.out_byte),
		.out_status (out_ch.status),
		.out_last   (out_ch.last)
	);

endmodule

[dv/e164_to_enum_domain_checker.sv]
// Checker for the E.164 to ENUM domain builder: watches both channels and the capacity port,
// predicts every domain beat and compares it with what the block sends.
// Depends on e164_pkg and the channel interfaces in e164_if.
`timescale 1ns / 1ps

module e164_to_enum_domain_checker
	import e164_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	e164_in_if               in_ch,
	e164_out_if              out_ch,
	output int               fail_count,
	output int               pending
);

	// One predicted output beat.
	typedef struct packed {
		logic [7:0] ch;
		status_t    st;
		logic       last;
	} domain_beat_t;

	domain_beat_t     domain_q[$];
	domain_beat_t     want;
	logic [CAP_W-1:0] capacity;
	logic [3:0]       digit_mem [MAX_DIGITS];
	logic [CNT_W-1:0] n_digits;
	logic             plus_seen;
	logic             lead_seen;
	status_t          num_err;
	logic             apex_bad;
	logic             label_open;
	logic [CAP_W-1:0] apex_chars;
	int               n_fail = 0;

	assign fail_count = n_fail;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_label_char(input logic [7:0] c);
		return is_digit(c) || (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)
			|| c == CH_DASH;
	endfunction

	function automatic logic is_skip(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_DASH || c == CH_LPAREN
			|| c == CH_RPAREN || c == CH_DOT;
	endfunction

	// Everything but the capacity goes back to its idle value.
	function automatic void clear_run();
		foreach (digit_mem[i]) digit_mem[i] = 4'd0;
		n_digits   = '0;
		plus_seen  = 1'b0;
		lead_seen  = 1'b0;
		num_err    = ST_OK;
		apex_bad   = 1'b0;
		label_open = 1'b0;
		apex_chars = '0;
	endfunction

	function automatic void push_beat(input logic [7:0] c, input status_t st, input logic lst);
		domain_q.push_back('{ch: c, st: st, last: lst});
	endfunction

	// Advances the run state by one input character and queues the beats it produces.
	function automatic void predict_domain(input logic [7:0] c, input logic apex, input logic fin);
		logic              ends_dot;
		logic              apex_ok;
		logic [NEED_W-1:0] need;
		status_t           st;

		if (!apex) begin
			// Once the number is in error, further number characters change nothing.
			if (num_err == ST_OK) begin
				if (is_digit(c)) begin
					if (n_digits >= MAX_DIGITS) begin
						num_err = ST_TOO_MANY;
					end else begin
						digit_mem[n_digits] = c[3:0];
						n_digits            = n_digits + 1'b1;
						lead_seen           = 1'b1;
					end
				end else if (c == CH_PLUS) begin
					if (plus_seen || lead_seen) begin
						num_err = ST_INVALID;
					end else begin
						plus_seen = 1'b1;
						lead_seen = 1'b1;
					end
				end else if (!is_skip(c)) begin
					num_err = ST_INVALID;
				end
			end
			// A good number goes out reversed, one dot after each digit.
			if (fin && num_err == ST_OK && n_digits != 0 && digit_mem[0] != 4'd0) begin
				for (int i = int'(n_digits) - 1; i >= 0; i--) begin
					push_beat(CH_ZERO + 8'(digit_mem[i]), ST_OK, 1'b0);
					push_beat(CH_DOT, ST_OK, 1'b0);
				end
			end
			return;
		end

		// Label rules for the apex.
		if (is_label_char(c)) begin
			label_open = 1'b1;
		end else if (c == CH_DOT) begin
			if (!label_open && !fin)
				apex_bad = 1'b1;
			label_open = 1'b0;
		end else begin
			apex_bad = 1'b1;
		end
		if (apex_chars != LEN_MAX)
			apex_chars = apex_chars + 1'b1;

		if (!fin) begin
			push_beat(c, ST_OK, 1'b0);
			return;
		end

		// Final apex character: judge the whole run.
		ends_dot = (c == CH_DOT);
		apex_ok  = !apex_bad && (label_open || ends_dot);
		need     = NEED_W'(n_digits) * 2 + NEED_W'(apex_chars) + NEED_W'(ends_dot ? 0 : 1) + 1;
		if (capacity == '0 || !apex_ok)
			st = ST_INVALID;
		else if (num_err != ST_OK)
			st = num_err;
		else if (n_digits == 0 || digit_mem[0] == 4'd0)
			st = ST_INVALID;
		else if (need > NEED_W'(capacity))
			st = ST_NO_SPACE;
		else
			st = ST_OK;

		if (ends_dot) begin
			push_beat(c, st, 1'b1);
		end else begin
			push_beat(c, ST_OK, 1'b0);
			push_beat(CH_DOT, st, 1'b1);
		end
		clear_run();
	endfunction

	// Output beats are checked before the input beat of the same edge is predicted,
	// since a character cannot produce a beat in the cycle it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity = CAP_RESET;
			clear_run();
			domain_q.delete();
			pending <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (domain_q.size() == 0) begin
					$display("%0t: unexpected domain beat: byte %02h status %0d last %0b",
						$time, out_ch.out_byte, out_ch.status, out_ch.last);
					n_fail++;
				end else begin
					want = domain_q.pop_front();
					if (out_ch.out_byte !== want.ch || out_ch.status !== want.st
						|| out_ch.last !== want.last) begin
						$display({"%0t: domain beat mismatch: expected byte %02h status %0d",
							" last %0b, got byte %02h status %0d last %0b"},
							$time, want.ch, want.st, want.last,
							out_ch.out_byte, out_ch.status, out_ch.last);
						n_fail++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_domain(in_ch.in_byte, in_ch.is_apex, in_ch.is_final);
			if (cfg_we)
				capacity = cfg_wdata;
			pending <= domain_q.size();
		end
	end

endmodule

[dv/e164_to_enum_domain_top_tb.sv]
// Testbench top for the E.164 to ENUM domain builder: clock, reset, capacity writes,
// number and apex character streams, output back-pressure and the verdict.
// Depends on e164_pkg, e164_if, the block and e164_to_enum_domain_checker.
`timescale 1ns / 1ps

module e164_to_enum_domain_top_tb;
	import e164_pkg::*;

	localparam logic [7:0] SKIP_CHARS [6] = '{CH_SPACE, CH_TAB, CH_DASH, CH_LPAREN, CH_RPAREN,
		CH_DOT};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	int               chars_sent = 0;
	logic             in_quiet   = 1'b0;
	logic             hold_req   = 1'b0;

	e164_in_if  in_ch ();
	e164_out_if out_ch ();

	e164_to_enum_domain_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	e164_to_enum_domain_checker domain_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[e164_to_enum_domain_top] ERROR");
		$finish;
	end

	// Offers one character after a random gap and returns at the edge that takes it.
	// Valid stays high on return, so a following call either keeps it up or drops it.
	task automatic send_char(input logic [7:0] c, input logic apex, input logic fin);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.in_byte  <= c;
		in_ch.is_apex  <= apex;
		in_ch.is_final <= fin;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s, input logic apex);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], apex, i == s.len() - 1);
	endtask

	function automatic logic [7:0] label_char();
		case ($urandom_range(0, 3))
			0: return CH_ZERO + 8'($urandom_range(0, 9));
			1: return CH_LC_A + 8'($urandom_range(0, 25));
			2: return CH_UC_A + 8'($urandom_range(0, 25));
			default: return CH_DASH;
		endcase
	endfunction

	// Number part: mostly well-formed digit strings with separators, some broken, some noise.
	task automatic send_number();
		logic [7:0] text[$];
		int         kind;
		int         ndig;
		int         fin_mode;
		kind = $urandom_range(0, 11);
		// Some runs carry no number at all and go straight to the apex.
		if (kind == 11)
			return;
		if (kind >= 9) begin
			repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 1) == 1)
				text.push_back(CH_PLUS);
			ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 15);
			for (int i = 0; i < ndig; i++) begin
				if (i == 0)
					text.push_back(($urandom_range(0, 7) == 0) ? CH_ZERO
						: CH_ZERO + 8'($urandom_range(1, 9)));
				else
					text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 2) == 0)
					text.push_back(SKIP_CHARS[$urandom_range(0, 5)]);
			end
			// Broken numbers get a stray plus or an arbitrary byte somewhere.
			if (kind >= 7)
				text.insert($urandom_range(0, text.size()), ($urandom_range(0, 1) == 1)
					? CH_PLUS : 8'($urandom_range(0, 255)));
		end
		// Usually one final character; sometimes none, sometimes the number is extended
		// after its final character and closed a second time.
		fin_mode = $urandom_range(0, 9);
		foreach (text[i])
			send_char(text[i], 1'b0, fin_mode != 0 && i == text.size() - 1);
		if (fin_mode == 1) begin
			send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b0);
			send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b1);
		end
	endtask

	// Apex part: mostly dotted labels, some with an empty label or a bad byte, some noise.
	task automatic send_apex();
		logic [7:0] text[$];
		int         kind;
		int         nlab;
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(1, 6))
				text.push_back(($urandom_range(0, 3) == 0) ? CH_DOT : 8'($urandom_range(0, 255)));
		end else begin
			nlab = $urandom_range(1, 3);
			for (int l = 0; l < nlab; l++) begin
				if (l > 0)
					text.push_back(CH_DOT);
				repeat ($urandom_range(1, 8)) text.push_back(label_char());
			end
			if ($urandom_range(0, 1) == 1)
				text.push_back(CH_DOT);
			if (kind >= 7)
				text.insert($urandom_range(0, text.size()), ($urandom_range(0, 1) == 1)
					? CH_DOT : 8'($urandom_range(0, 255)));
		end
		foreach (text[i])
			send_char(text[i], 1'b1, i == text.size() - 1);
	endtask

	task automatic send_query_run();
		send_number();
		send_apex();
	endtask

	// The capacity is only changed once the block has drained every beat of the last run.
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Output side: random stalls per beat, quiet stretches, and one long hold-off
	// that backs the block up into its input.
	initial begin
		int   stall;
		int   beats;
		logic out_quiet;
		logic held;
		beats        = 0;
		out_quiet    = 1'b0;
		held         = 1'b0;
		out_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (beats % 32 == 0)
				out_quiet = ($urandom_range(0, 2) == 0);
			stall = out_quiet ? 0 : $urandom_range(0, 10);
			if (hold_req && !held) begin
				stall = 300;
				held  = 1'b1;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			beats++;
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [CAP_W-1:0] caps [7];
		int               phase_end;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		in_ch.valid    = 1'b0;
		in_ch.in_byte  = '0;
		in_ch.is_apex  = 1'b0;
		in_ch.is_final = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed runs at the reset capacity.
		// Plus, every separator and an inner zero; apex already ends in a dot.
		send_text("+9(0)-\t. 1", 1'b0);
		send_text("a-Z9.", 1'b1);
		// Leading zero; empty label inside the apex before a final dot.
		send_text("0", 1'b0);
		send_text("..", 1'b1);
		// Plus after a digit, then a byte that is ignored once the number is bad;
		// a NUL apex byte.
		send_char("1", 1'b0, 1'b0);
		send_char(CH_PLUS, 1'b0, 1'b0);
		send_char(8'hFF, 1'b0, 1'b1);
		send_char(8'h00, 1'b1, 1'b1);
		// Apex with no number before it.
		send_text("z", 1'b1);
		// A number closed twice is emitted twice, the second time extended.
		send_text("4", 1'b0);
		send_text("2", 1'b0);
		send_text("b", 1'b1);

		// Random runs over several capacities, the extremes among them.
		caps = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'($urandom_range(12, 45)),
			11'($urandom_range(1, 1024)), CAP_RESET};
		foreach (caps[p]) begin
			write_capacity(caps[p]);
			in_quiet = ($urandom_range(0, 2) == 0);
			// At the largest capacity the receiver holds off for a long stretch
			// while characters keep coming.
			if (caps[p] == 11'd2047) begin
				hold_req = 1'b1;
				send_char("7", 1'b0, 1'b1);
			end
			phase_end = chars_sent + 16;
			while (chars_sent < phase_end) send_query_run();
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[e164_to_enum_domain_top] OK");
		else
			$display("[e164_to_enum_domain_top] ERROR");
		$finish;
	end

endmodule
